>>> sv/noise_gate_peak_smoothed_gain_macros.svh
// ----------------------------------------------------------------------------
// Noise gate assertion macros
// Shared property forms for the port checker: same-cycle and next-cycle
// implications, both disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef NOISE_GATE_PEAK_SMOOTHED_GAIN_MACROS_SVH
`define NOISE_GATE_PEAK_SMOOTHED_GAIN_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define NGPSG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define NGPSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ngpsg_pkg.sv
// ----------------------------------------------------------------------------
// Noise gate package
// Widths, register indexes, reset values and controller command types.
// ----------------------------------------------------------------------------
`default_nettype none

package ngpsg_pkg;

  localparam int unsigned CHANNELS   = 2;
  localparam bit          TWO_CH     = (CHANNELS >= 2);

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned GAIN_W     = 17;
  localparam int unsigned COEFF_W    = 16;
  localparam int unsigned THRESH_W   = 15;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PROD_W     = 34;

  localparam logic [GAIN_W-1:0]   GAIN_ONE        = 17'd65536;
  localparam logic [THRESH_W-1:0] THRESHOLD_RST   = 15'd983;
  localparam logic [COEFF_W-1:0]  ATTACK_RST      = 16'd0;
  localparam logic [COEFF_W-1:0]  RELEASE_RST     = 16'd63067;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_ATTACK    = 2'd1,
    REG_RELEASE   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    MUL_GAIN  = 2'd0,
    MUL_LEFT  = 2'd1,
    MUL_RIGHT = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     gain_we;
    logic     left_we;
    logic     out_load;
  } cmd_t;

endpackage

`default_nettype wire

>>> sv/ngpsg_ifs.sv
// ----------------------------------------------------------------------------
// Noise gate channel interfaces
// Frame input, gated result and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface ngpsg_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_left;
  logic signed [15:0] sample_right;

  modport source (output valid, sample_left, sample_right, input ready);
  modport sink   (input valid, sample_left, sample_right, output ready);
endinterface

interface ngpsg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] gated_left;
  logic signed [15:0] gated_right;
  logic        [16:0] gain_now;

  modport source (output valid, gated_left, gated_right, gain_now, input ready);
  modport sink   (input valid, gated_left, gated_right, gain_now, output ready);
endinterface

interface ngpsg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/noise_gate_peak_smoothed_gain.sv
// ----------------------------------------------------------------------------
// Stereo noise gate with smoothed gain
// Peak level against a threshold sets the target; the gain follows it by
// a one-pole attack/release step and scales both samples.
//
//   channel   dir  handshake      payload
//   in_port   in   valid/ready    sample_left, sample_right
//   out_port  out  valid/ready    gated_left, gated_right, gain_now
//   cfg_port  in   valid/ready    index, data
//
// A frame is handled in order: accept, then three passes through the single
// 17x18 multiplier (coefficient times gain, left times gain, right times
// gain) and a result load. A held result stalls the load step, and no new
// frame is accepted until it is done. Register writes complete every cycle.
// Synchronous reset closes the gate (gain 0) and restores register values.
// ----------------------------------------------------------------------------
`default_nettype none

module noise_gate_peak_smoothed_gain (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ngpsg_in_if.sink    in_port,
  ngpsg_out_if.source out_port,
  ngpsg_cfg_if.sink   cfg_port
);
  import ngpsg_pkg::*;

  cmd_t cmd;

  assign cfg_port.ready = 1'b1;

  ngpsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_port.valid),
    .in_ready  (in_port.ready),
    .out_valid (out_port.valid),
    .out_ready (out_port.ready),
    .cmd       (cmd)
  );

  ngpsg_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sample_left  (in_port.sample_left),
    .sample_right (in_port.sample_right),
    .cfg_valid    (cfg_port.valid),
    .cfg_index    (cfg_port.index),
    .cfg_data     (cfg_port.data),
    .gated_left   (out_port.gated_left),
    .gated_right  (out_port.gated_right),
    .gain_now     (out_port.gain_now)
  );

endmodule

`default_nettype wire

>>> sv/ngpsg_ctrl.sv
// ----------------------------------------------------------------------------
// Noise gate controller
// Sequences the shared multiplier over gain, left and right passes and
// holds the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ngpsg_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ngpsg_pkg::cmd_t    cmd
);
  import ngpsg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAIN,
    S_LEFT,
    S_RIGHT,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = MUL_GAIN;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_GAIN;
        end
      end
      S_GAIN: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GAIN;
        state_nxt   = S_LEFT;
      end
      S_LEFT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LEFT;
        cmd.gain_we = 1'b1;
        state_nxt   = S_RIGHT;
      end
      S_RIGHT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RIGHT;
        cmd.left_we = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/ngpsg_dp.sv
// ----------------------------------------------------------------------------
// Noise gate datapath
// Level detect, coefficient select, one shared multiplier, gain register,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ngpsg_dp (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire ngpsg_pkg::cmd_t                        cmd,
  input  wire logic signed [ngpsg_pkg::SAMPLE_W-1:0]  sample_left,
  input  wire logic signed [ngpsg_pkg::SAMPLE_W-1:0]  sample_right,
  input  wire logic                                   cfg_valid,
  input  wire logic [ngpsg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [ngpsg_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic signed [ngpsg_pkg::SAMPLE_W-1:0]       gated_left,
  output logic signed [ngpsg_pkg::SAMPLE_W-1:0]       gated_right,
  output logic [ngpsg_pkg::GAIN_W-1:0]                gain_now
);
  import ngpsg_pkg::*;

  logic [THRESH_W-1:0]        threshold_r;
  logic [COEFF_W-1:0]         attack_r;
  logic [COEFF_W-1:0]         release_r;
  logic [GAIN_W-1:0]          gain_r;
  logic [GAIN_W-1:0]          gain_upd;
  logic signed [SAMPLE_W-1:0] left_r;
  logic signed [SAMPLE_W-1:0] right_r;
  logic                       target_r;
  logic [COEFF_W-1:0]         coeff_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SAMPLE_W-1:0] left_q_r;
  logic signed [SAMPLE_W-1:0] gated_left_r;
  logic signed [SAMPLE_W-1:0] gated_right_r;
  logic [GAIN_W-1:0]          gain_now_r;

  logic [SAMPLE_W-1:0]        mag_l;
  logic [SAMPLE_W-1:0]        mag_r;
  logic [SAMPLE_W-1:0]        level;
  logic                       target;
  logic [GAIN_W-1:0]          step_add;
  logic [GAIN_W:0]            gain_sum;
  logic signed [GAIN_W-1:0]   mul_a;
  logic signed [GAIN_W:0]     mul_b;
  logic signed [PROD_W:0]     mul_p;

  // level and target
  assign mag_l  = sample_left[SAMPLE_W-1]  ? (~sample_left + 1'b1)  : sample_left;
  assign mag_r  = sample_right[SAMPLE_W-1] ? (~sample_right + 1'b1) : sample_right;
  assign level  = (TWO_CH && (mag_r > mag_l)) ? mag_r : mag_l;
  assign target = (level > {1'b0, threshold_r});

  // new gain: (c*g)>>16 plus (1-c) when the gate is open
  assign step_add = target_r ? (GAIN_ONE - {1'b0, coeff_r}) : '0;
  assign gain_sum = {1'b0, prod_r[GAIN_W+15:16]} + {1'b0, step_add};
  assign gain_upd = gain_sum[GAIN_W-1:0];

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_GAIN: begin
        mul_a = signed'({1'b0, coeff_r});
        mul_b = signed'({1'b0, gain_r});
      end
      MUL_LEFT: begin
        mul_a = GAIN_W'(left_r);
        mul_b = signed'({1'b0, gain_upd});
      end
      MUL_RIGHT: begin
        mul_a = GAIN_W'(right_r);
        mul_b = signed'({1'b0, gain_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      attack_r    <= ATTACK_RST;
      release_r   <= RELEASE_RST;
      gain_r      <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_THRESHOLD: threshold_r <= cfg_data[THRESH_W-1:0];
          REG_ATTACK:    attack_r    <= cfg_data;
          REG_RELEASE:   release_r   <= cfg_data;
          default:       ;
        endcase
      end
      if (cmd.gain_we) begin
        gain_r <= gain_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      left_r   <= sample_left;
      right_r  <= sample_right;
      target_r <= target;
      coeff_r  <= (target && (gain_r != GAIN_ONE)) ? attack_r : release_r;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_p[PROD_W-1:0];
    end
    if (cmd.left_we) begin
      left_q_r <= prod_r[SAMPLE_W+15:16];
    end
    if (cmd.out_load) begin
      gated_left_r  <= left_q_r;
      gated_right_r <= TWO_CH ? prod_r[SAMPLE_W+15:16] : '0;
      gain_now_r    <= gain_r;
    end
  end

  assign gated_left  = gated_left_r;
  assign gated_right = gated_right_r;
  assign gain_now    = gain_now_r;

endmodule

`default_nettype wire

>>> sv/ngpsg_checker.sv
// ----------------------------------------------------------------------------
// Noise gate port checker
// Port-level properties of the gate, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "noise_gate_peak_smoothed_gain_macros.svh"

module ngpsg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_gated_left,
  input wire logic [15:0] out_gated_right,
  input wire logic [16:0] out_gain_now
);

  `NGPSG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_gated_left) && $stable(out_gated_right) && $stable(out_gain_now), "stalled transfer changed")
  `NGPSG_ASSERT_NOW(a_gain_range, clk, rst_n, out_valid, out_gain_now <= 17'd65536, "gain above unity")
  `NGPSG_ASSERT_NOW(a_closed_mute, clk, rst_n, out_valid && (out_gain_now == 17'd0), (out_gated_left == 16'd0) && (out_gated_right == 16'd0), "closed gate passed signal")
  `NGPSG_ASSERT_NEXT(a_one_frame, clk, rst_n, in_valid && in_ready, !in_ready, "second frame taken during work")

endmodule

bind noise_gate_peak_smoothed_gain ngpsg_checker u_ngpsg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_port.valid),
  .in_ready        (in_port.ready),
  .out_valid       (out_port.valid),
  .out_ready       (out_port.ready),
  .out_gated_left  (out_port.gated_left),
  .out_gated_right (out_port.gated_right),
  .out_gain_now    (out_port.gain_now)
);

`default_nettype wire
